### sv/kvcrp_pkg.sv
// Shared types and constants for the key-value cache reply parser.
// Used by every module of the block; no dependencies.
package kvcrp_pkg;

	localparam int HEADER_BYTES = 24;
	localparam logic [7:0] REPLY_MAGIC = 8'h81;
	localparam logic [7:0] RAW_TYPE = 8'h00;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	typedef enum logic [1:0] {
		OK_VALUE = 2'd0,
		OK_DONE  = 2'd1,
		OK_ERROR = 2'd2
	} out_kind_t;

	typedef enum logic [1:0] {
		ERR_MAGIC  = 2'd0,
		ERR_DTYPE  = 2'd1,
		ERR_LENGTH = 2'd2
	} err_code_t;

	typedef struct packed {
		out_kind_t   out_kind;
		logic [7:0]  value_byte;
		logic        last_of_reply;
		logic [15:0] reply_status;
		logic [31:0] value_length;
		err_code_t   error_code;
	} result_t;

	typedef struct packed {
		logic    push;
		result_t data;
	} q_wr_t;

	typedef struct packed {
		logic    empty;
		result_t data;
	} q_rd_t;

endpackage

### sv/kvcrp_front.sv
// Front end: accepts stream words, tracks header/body position, classifies
// each byte and pushes at most one result word into the queue.
// Depends on kvcrp_pkg.
module kvcrp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 kind,
	input  logic [7:0]           in_byte,
	output kvcrp_pkg::q_wr_t     q_wr
);

	localparam logic [32:0] HDR_BYTES = 33'(kvcrp_pkg::HEADER_BYTES);
	localparam logic [32:0] HDR_LAST  = 33'(kvcrp_pkg::HEADER_BYTES - 1);
	localparam logic [4:0]  P_MAGIC   = 5'd0;
	localparam logic [4:0]  P_KEY_HI  = 5'd2;
	localparam logic [4:0]  P_KEY_LO  = 5'd3;
	localparam logic [4:0]  P_EXTRAS  = 5'd4;
	localparam logic [4:0]  P_DTYPE   = 5'd5;
	localparam logic [4:0]  P_STAT_HI = 5'd6;
	localparam logic [4:0]  P_STAT_LO = 5'd7;
	localparam logic [4:0]  P_BODY_3  = 5'd8;
	localparam logic [4:0]  P_BODY_2  = 5'd9;
	localparam logic [4:0]  P_BODY_1  = 5'd10;
	localparam logic [4:0]  P_BODY_0  = 5'd11;
	localparam logic [4:0]  P_SUM     = 5'd12;

	logic [32:0] pos_q;
	logic [31:0] body_q;
	logic [15:0] key_q;
	logic [7:0]  extras_q;
	logic [15:0] status_q;
	logic [16:0] vs_q;
	logic [32:0] vpos_q;
	logic [32:0] final_q;
	logic [31:0] vlen_q;
	logic        halted_q;

	logic in_header;
	logic at_last_hdr;
	logic magic_bad;
	logic dtype_bad;
	logic len_bad;
	logic body_last;
	logic body_value;
	logic live;

	assign live        = accept && !kind && !halted_q;
	assign in_header   = pos_q < HDR_BYTES;
	assign at_last_hdr = pos_q == HDR_LAST;
	assign magic_bad   = pos_q[4:0] == P_MAGIC && in_byte != kvcrp_pkg::REPLY_MAGIC;
	assign dtype_bad   = pos_q[4:0] == P_DTYPE && in_byte != kvcrp_pkg::RAW_TYPE;
	assign len_bad     = at_last_hdr && {15'd0, vs_q} > body_q;
	assign body_last   = pos_q >= final_q;
	assign body_value  = pos_q >= vpos_q;

	always_comb begin
		q_wr.push = 1'b0;
		q_wr.data = '0;
		if (live) begin
			if (in_header) begin
				if (magic_bad || dtype_bad || len_bad) begin
					q_wr.push = 1'b1;
					q_wr.data.out_kind = kvcrp_pkg::OK_ERROR;
					q_wr.data.error_code = magic_bad ? kvcrp_pkg::ERR_MAGIC :
						(dtype_bad ? kvcrp_pkg::ERR_DTYPE : kvcrp_pkg::ERR_LENGTH);
				end else if (at_last_hdr && body_q == 32'd0) begin
					q_wr.push = 1'b1;
					q_wr.data.out_kind = kvcrp_pkg::OK_DONE;
					q_wr.data.last_of_reply = 1'b1;
					q_wr.data.reply_status = status_q;
				end
			end else if (body_value || body_last) begin
				q_wr.push = 1'b1;
				q_wr.data.out_kind = body_value ? kvcrp_pkg::OK_VALUE : kvcrp_pkg::OK_DONE;
				q_wr.data.value_byte = body_value ? in_byte : 8'd0;
				q_wr.data.last_of_reply = body_last;
				q_wr.data.reply_status = status_q;
				q_wr.data.value_length = vlen_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			body_q   <= '0;
			key_q    <= '0;
			extras_q <= '0;
			status_q <= '0;
			vs_q     <= '0;
			vpos_q   <= '0;
			final_q  <= '0;
			vlen_q   <= '0;
			halted_q <= 1'b0;
		end else if (accept && kind) begin
			pos_q    <= '0;
			body_q   <= '0;
			key_q    <= '0;
			extras_q <= '0;
			status_q <= '0;
			vs_q     <= '0;
			vpos_q   <= '0;
			final_q  <= '0;
			vlen_q   <= '0;
			halted_q <= 1'b0;
		end else if (live) begin
			if (in_header) begin
				case (pos_q[4:0])
					P_KEY_HI:  key_q[15:8]    <= in_byte;
					P_KEY_LO:  key_q[7:0]     <= in_byte;
					P_EXTRAS:  extras_q       <= in_byte;
					P_STAT_HI: status_q[15:8] <= in_byte;
					P_STAT_LO: status_q[7:0]  <= in_byte;
					P_BODY_3:  body_q         <= {in_byte, 24'd0};
					P_BODY_2:  body_q[23:16]  <= in_byte;
					P_BODY_1:  body_q[15:8]   <= in_byte;
					P_BODY_0:  body_q[7:0]    <= in_byte;
					P_SUM:     vs_q           <= {9'd0, extras_q} + {1'b0, key_q};
					default: ;
				endcase
				if (magic_bad || dtype_bad || len_bad) begin
					halted_q <= 1'b1;
				end else if (at_last_hdr && body_q == 32'd0) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 33'd1;
				end
				if (at_last_hdr) begin
					final_q <= HDR_LAST + {1'b0, body_q};
					vlen_q  <= body_q - {15'd0, vs_q};
					vpos_q  <= {16'd0, vs_q} + HDR_BYTES;
				end
			end else begin
				pos_q <= body_last ? '0 : pos_q + 33'd1;
			end
		end
	end

endmodule

### sv/kvcrp_fifo.sv
// Short result queue between the front end and the output stage.
// Depends on kvcrp_pkg.
module kvcrp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  kvcrp_pkg::q_wr_t  q_wr,
	input  logic              pop,
	output logic              full,
	output kvcrp_pkg::q_rd_t  q_rd
);

	kvcrp_pkg::result_t mem_q [kvcrp_pkg::FIFO_DEPTH];
	logic [kvcrp_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [kvcrp_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [kvcrp_pkg::FIFO_AW:0]   count_q;
	logic do_push;
	logic do_pop;

	assign full       = count_q == (kvcrp_pkg::FIFO_AW+1)'(kvcrp_pkg::FIFO_DEPTH);
	assign q_rd.empty = count_q == '0;
	assign q_rd.data  = mem_q[rd_ptr_q];
	assign do_push    = q_wr.push && !full;
	assign do_pop     = pop && !q_rd.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/kvcrp_back.sv
// Output stage: pops result words from the queue into the output register.
// Depends on kvcrp_pkg.
module kvcrp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  kvcrp_pkg::q_rd_t   q_rd,
	output logic               pop,
	input  logic               out_ready,
	output logic               out_valid,
	output kvcrp_pkg::result_t res
);

	logic               valid_q;
	kvcrp_pkg::result_t res_q;

	assign pop       = !q_rd.empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= q_rd.data;
		end
	end

endmodule

### sv/kv_cache_reply_parser.sv
// Binary key-value cache reply parser, top level.
// Instantiates kvcrp_front, kvcrp_fifo and kvcrp_back; uses kvcrp_pkg.
//
// Input channel (in_valid/in_ready): one word per cycle, kind 0 carries a
// reply byte, kind 1 restarts the parser (clears header state and any halt)
// and gives no result. Output channel (out_valid/out_ready): zero or one
// result per input word, in input order.
// Each reply is a 24-byte header, then extras and key (skipped), then value
// bytes, each one emitted as a value result; the reply's final byte is
// flagged last_of_reply, and a reply with an empty value gives one done
// result. A bad magic, bad data type or oversized extras plus key gives one
// error result and halts the parser until a restart word.
// Throughput: one word per cycle while out_ready stays high. A result is
// written by the front end into a 4-entry queue at the accepting edge, and
// the output register then takes it from the queue; it waits in the queue
// while the output stalls.
// When out_ready is low, results collect in the queue; in_ready drops only
// when the queue is full, and rises again as the output drains.
// Reset: all parser state cleared, queue empty, out_valid low.
module kv_cache_reply_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [7:0]  value_byte,
	output logic        last_of_reply,
	output logic [15:0] reply_status,
	output logic [31:0] value_length,
	output logic [1:0]  error_code
);

	kvcrp_pkg::q_wr_t   q_wr;
	kvcrp_pkg::q_rd_t   q_rd;
	kvcrp_pkg::result_t res;
	logic               full;
	logic               pop;

	assign in_ready = !full;

	kvcrp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_valid && in_ready),
		.kind    (kind),
		.in_byte (in_byte),
		.q_wr    (q_wr)
	);

	kvcrp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.full   (full),
		.q_rd   (q_rd)
	);

	kvcrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rd      (q_rd),
		.pop       (pop),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res       (res)
	);

	assign out_kind      = res.out_kind;
	assign value_byte    = res.value_byte;
	assign last_of_reply = res.last_of_reply;
	assign reply_status  = res.reply_status;
	assign value_length  = res.value_length;
	assign error_code    = res.error_code;

endmodule

### sv/kvcrp_checker.sv
// Port-level checks for kv_cache_reply_parser, bound to the top level.
// Depends on kvcrp_pkg.
module kvcrp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_kind,
	input logic        last_of_reply,
	input logic [15:0] reply_status,
	input logic [31:0] value_length,
	input logic [1:0]  error_code
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_kind != 2'd3)
		else $error("illegal out_kind");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == kvcrp_pkg::OK_ERROR |->
			!last_of_reply && reply_status == 16'd0 && value_length == 32'd0 &&
			error_code != 2'd3)
		else $error("error word carries reply fields");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == kvcrp_pkg::OK_DONE |-> last_of_reply)
		else $error("done word without last_of_reply");

	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != kvcrp_pkg::OK_ERROR |-> error_code == 2'd0)
		else $error("error_code set on non-error word");

endmodule

bind kv_cache_reply_parser kvcrp_checker u_kvcrp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_kind      (out_kind),
	.last_of_reply (last_of_reply),
	.reply_status  (reply_status),
	.value_length  (value_length),
	.error_code    (error_code)
);
